### src/sim_pkg.sv
// Shared types and constants for the subsampled image mean core.
package sim_pkg;

  localparam int PIXEL_BITS   = 8;
  localparam int SUM_BITS     = 32;
  localparam int FRAC_BITS    = 8;
  localparam int DIV_BITS     = SUM_BITS + FRAC_BITS;
  localparam int DIV_CNT_BITS = $clog2(DIV_BITS + 1);
  localparam int MEAN_BITS    = 16;
  localparam int RANK_BITS    = 8;
  localparam int CFG_IDX_BITS = 2;

  localparam logic [MEAN_BITS-1:0] MEAN_MAX   = 16'd65280;
  localparam logic [RANK_BITS-1:0] RANK_VALID = 8'd255;
  localparam logic [RANK_BITS-1:0] RANK_NONE  = 8'd0;

  localparam logic [CFG_IDX_BITS-1:0] CFG_STEP_X = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_STEP_Y = 2'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_HOLD
  } sim_state_t;

  typedef struct packed {
    logic take_px;
    logic blank;
    logic div_start;
    logic load_out;
  } sim_cmd_t;

  typedef struct packed {
    logic div_done;
  } sim_sts_t;

endpackage

### src/sim_if.sv
// Pixel and result stream interfaces with valid/ready handshake.
interface sim_in_if;
  logic                           valid;
  logic                           ready;
  logic [sim_pkg::PIXEL_BITS-1:0] pixel;
  logic                           end_of_row;
  logic                           end_of_frame;
  logic                           empty_frame;

  modport source(output valid, pixel, end_of_row, end_of_frame, empty_frame, input ready);
  modport sink(input valid, pixel, end_of_row, end_of_frame, empty_frame, output ready);
endinterface

interface sim_out_if;
  logic                          valid;
  logic                          ready;
  logic [sim_pkg::MEAN_BITS-1:0] mean_q8;
  logic [sim_pkg::RANK_BITS-1:0] rank;
  logic                          present;

  modport source(output valid, mean_q8, rank, present, input ready);
  modport sink(input valid, mean_q8, rank, present, output ready);
endinterface

### src/sim_ctrl.sv
// Controller state machine: handshakes, divide sequencing and result hand-off.
module sim_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_eof,
  input  logic              in_empty,
  output logic              in_ready,
  input  logic              out_ready,
  output logic              out_valid,
  input  sim_pkg::sim_sts_t sts,
  output sim_pkg::sim_cmd_t cmd
);
  import sim_pkg::*;

  sim_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    in_ready      = 1'b0;
    take          = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        take     = in_valid;
        if (take) begin
          if (in_empty) begin
            cmd.blank = 1'b1;
            state_nxt = ST_HOLD;
          end else begin
            cmd.take_px = 1'b1;
            if (in_eof) begin
              cmd.div_start = 1'b1;
              state_nxt     = ST_DIV;
            end
          end
        end
      end
      ST_DIV: begin
        if (sts.div_done) begin
          state_nxt = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_ready))
    else $error("result loaded over a pending transaction");

  a_start_div: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |=> (state_r == ST_DIV && !sts.div_done))
    else $error("divider not busy after start");

  a_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |=> (state_r == ST_DIV || state_r == ST_HOLD))
    else $error("illegal exit from divide");

  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.take_px || cmd.blank) |-> (state_r == ST_IDLE && !cmd.load_out))
    else $error("transaction taken while busy");

endmodule

### src/sim_div.sv
// Restoring divider, one quotient bit per cycle.
module sim_div #(
  parameter int COUNT_BITS = 24
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [sim_pkg::DIV_BITS-1:0]  dividend,
  input  logic [COUNT_BITS-1:0]         divisor,
  output logic                          done,
  output logic [sim_pkg::DIV_BITS-1:0]  quotient
);
  import sim_pkg::*;

  logic [DIV_CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic [DIV_BITS-1:0]     dvd_r, dvd_nxt;
  logic [COUNT_BITS-1:0]   rem_r, rem_nxt;
  logic [COUNT_BITS-1:0]   dsr_r;
  logic [COUNT_BITS:0]     trial;
  logic [COUNT_BITS-1:0]   diff;
  logic                    ge;

  assign trial = {rem_r, dvd_r[DIV_BITS-1]};
  assign ge    = trial >= {1'b0, dsr_r};
  assign diff  = trial[COUNT_BITS-1:0] - dsr_r;

  always_comb begin
    cnt_nxt = cnt_r;
    dvd_nxt = dvd_r;
    rem_nxt = rem_r;
    if (start) begin
      cnt_nxt = DIV_CNT_BITS'(DIV_BITS);
      dvd_nxt = dividend;
      rem_nxt = '0;
    end else if (cnt_r != '0) begin
      cnt_nxt = cnt_r - 1'b1;
      dvd_nxt = {dvd_r[DIV_BITS-2:0], ge};
      rem_nxt = ge ? diff : trial[COUNT_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      dsr_r <= (divisor == '0) ? COUNT_BITS'(1) : divisor;
    end
  end

  assign done     = (cnt_r == '0);
  assign quotient = dvd_r;

endmodule

### src/sim_dp.sv
// Datapath: stride registers, sampling phases, saturating sums and result register.
module sim_dp #(
  parameter int COUNT_BITS = 24,
  parameter int STEP_BITS  = 10
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  sim_pkg::sim_cmd_t                   cmd,
  output sim_pkg::sim_sts_t                   sts,
  input  logic                                cfg_we,
  input  logic [sim_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [STEP_BITS-1:0]                cfg_data,
  input  logic [sim_pkg::PIXEL_BITS-1:0]      pixel,
  input  logic                                end_of_row,
  output logic [sim_pkg::MEAN_BITS-1:0]       mean_q8,
  output logic [sim_pkg::RANK_BITS-1:0]       rank,
  output logic                                present
);
  import sim_pkg::*;

  logic [STEP_BITS-1:0]  step_x_r, step_y_r;
  logic [STEP_BITS-1:0]  col_r, col_nxt, row_r, row_nxt;
  logic [SUM_BITS-1:0]   sum_r, sum_nxt;
  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt;
  logic [SUM_BITS:0]     sum_ext;
  logic                  sampled;
  logic [STEP_BITS-1:0]  col_adv, row_adv;
  logic                  res_present_r;
  logic [DIV_BITS-1:0]   quotient;
  logic                  div_done;
  logic [MEAN_BITS-1:0]  mean_clamped;
  logic [MEAN_BITS-1:0]  mean_r;
  logic [RANK_BITS-1:0]  rank_r;
  logic                  present_r;

  function automatic logic [STEP_BITS-1:0] advance(input logic [STEP_BITS-1:0] phase,
                                                   input logic [STEP_BITS-1:0] step);
    logic [STEP_BITS:0] inc;
    logic [STEP_BITS:0] lim;
    inc = {1'b0, phase} + 1'b1;
    lim = (step == '0) ? (STEP_BITS+1)'(1) : {1'b0, step};
    return (inc >= lim) ? '0 : inc[STEP_BITS-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_x_r <= STEP_BITS'(1);
      step_y_r <= STEP_BITS'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_STEP_X: step_x_r <= cfg_data;
        CFG_STEP_Y: step_y_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign sampled = (col_r == '0) && (row_r == '0);
  assign sum_ext = {1'b0, sum_r} + {{(SUM_BITS+1-PIXEL_BITS){1'b0}}, pixel};
  assign col_adv = advance(col_r, step_x_r);
  assign row_adv = advance(row_r, step_y_r);

  always_comb begin
    sum_nxt = sum_r;
    cnt_nxt = cnt_r;
    if (sampled) begin
      sum_nxt = sum_ext[SUM_BITS] ? '1 : sum_ext[SUM_BITS-1:0];
      if (cnt_r != '1) begin
        cnt_nxt = cnt_r + 1'b1;
      end
    end
    col_nxt = col_adv;
    row_nxt = row_r;
    if (end_of_row) begin
      col_nxt = '0;
      row_nxt = row_adv;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      cnt_r <= '0;
      col_r <= '0;
      row_r <= '0;
    end else if (cmd.blank || cmd.div_start) begin
      sum_r <= '0;
      cnt_r <= '0;
      col_r <= '0;
      row_r <= '0;
    end else if (cmd.take_px) begin
      sum_r <= sum_nxt;
      cnt_r <= cnt_nxt;
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  sim_div #(
    .COUNT_BITS(COUNT_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend ({sum_nxt, {FRAC_BITS{1'b0}}}),
    .divisor  (cnt_nxt),
    .done     (div_done),
    .quotient (quotient)
  );

  assign sts.div_done = div_done;
  assign mean_clamped = (quotient > DIV_BITS'(MEAN_MAX)) ? MEAN_MAX : quotient[MEAN_BITS-1:0];

  always_ff @(posedge clk) begin
    if (cmd.blank) begin
      res_present_r <= 1'b0;
    end else if (cmd.div_start) begin
      res_present_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      mean_r    <= res_present_r ? mean_clamped : '0;
      rank_r    <= res_present_r ? RANK_VALID : RANK_NONE;
      present_r <= res_present_r;
    end
  end

  assign mean_q8 = mean_r;
  assign rank    = rank_r;
  assign present = present_r;

endmodule

### src/subsampled_image_mean_core.sv
// Top level of the subsampled image mean core.
// Pixel transactions are taken one per cycle while no frame result is being formed or waiting for the output.
// End of frame: the 40-step divider runs one quotient bit per cycle, then the result is
// loaded into the output register once it is free and offered; input is held off meanwhile.
// Empty frame marker: an empty result is loaded into the output register once it is free.
// Synchronous reset clears strides to 1 and clears sums, counts, phases and handshakes.
module subsampled_image_mean_core #(
  parameter int COUNT_BITS = 24,
  parameter int STEP_BITS  = 10
) (
  input  logic                              clk,
  input  logic                              rst_n,
  sim_in_if.sink                            in_px,
  sim_out_if.source                         out_res,
  input  logic                              cfg_we,
  input  logic [sim_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [STEP_BITS-1:0]              cfg_data
);
  import sim_pkg::*;

  sim_cmd_t cmd;
  sim_sts_t sts;

  sim_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_px.valid),
    .in_eof    (in_px.end_of_frame),
    .in_empty  (in_px.empty_frame),
    .in_ready  (in_px.ready),
    .out_ready (out_res.ready),
    .out_valid (out_res.valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  sim_dp #(
    .COUNT_BITS(COUNT_BITS),
    .STEP_BITS (STEP_BITS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .pixel        (in_px.pixel),
    .end_of_row   (in_px.end_of_row),
    .mean_q8      (out_res.mean_q8),
    .rank         (out_res.rank),
    .present      (out_res.present)
  );

endmodule

### bench/tb_subsampled_image_mean_core.sv
// Self-checking testbench of the subsampled image mean core: directed and random frames.
module tb_subsampled_image_mean_core;
  timeunit 1ns;
  timeprecision 1ps;

  import sim_pkg::*;

  localparam int COUNT_BITS    = 24;
  localparam int STEP_BITS     = 10;
  localparam int SETTLE_CYCLES = 60;
  localparam int HOLD_CYCLES   = 400;
  localparam int QUIET_LIMIT   = 5000;
  localparam int PHASE_ITEMS   = 200;
  localparam int PRINT_LIMIT   = 100;

  typedef struct packed {
    logic [MEAN_BITS-1:0] mean_q8;
    logic [RANK_BITS-1:0] rank;
    logic                 present;
  } mean_result_t;

  class frame_mean_board;
    logic [STEP_BITS-1:0]  step_x;
    logic [STEP_BITS-1:0]  step_y;
    logic [STEP_BITS-1:0]  col_phase;
    logic [STEP_BITS-1:0]  row_phase;
    logic [SUM_BITS-1:0]   pixel_sum;
    logic [COUNT_BITS-1:0] sample_count;
    mean_result_t          pending_means[$];
    int                    errors;
    int                    checked;
    int                    empties;

    function new();
      step_x  = STEP_BITS'(1);
      step_y  = STEP_BITS'(1);
      errors  = 0;
      checked = 0;
      empties = 0;
      clear();
    endfunction

    function void clear();
      pixel_sum    = '0;
      sample_count = '0;
      col_phase    = '0;
      row_phase    = '0;
    endfunction

    function logic [STEP_BITS-1:0] next_phase(logic [STEP_BITS-1:0] phase,
                                              logic [STEP_BITS-1:0] stride);
      int unsigned s;
      s = (stride == 0) ? 1 : stride;
      if (phase + 1 >= s) begin
        return '0;
      end
      return phase + 1'b1;
    endfunction

    function void set_stride(logic [CFG_IDX_BITS-1:0] idx, logic [STEP_BITS-1:0] value);
      if (idx == CFG_STEP_X) begin
        step_x = value;
      end else if (idx == CFG_STEP_Y) begin
        step_y = value;
      end
    endfunction

    function void note_pixel(logic [PIXEL_BITS-1:0] pixel, logic eor, logic eof, logic empty);
      longint unsigned wide_sum;
      longint unsigned divisor;
      longint unsigned quotient;
      mean_result_t    res;
      if (empty) begin
        clear();
        res = '{mean_q8: '0, rank: RANK_NONE, present: 1'b0};
        pending_means = {pending_means, res};
        empties++;
        return;
      end
      if (col_phase == 0 && row_phase == 0) begin
        wide_sum  = 64'(pixel_sum) + 64'(pixel);
        pixel_sum = (wide_sum > 64'hFFFF_FFFF) ? '1 : wide_sum[SUM_BITS-1:0];
        if (sample_count != '1) begin
          sample_count++;
        end
      end
      if (eof) begin
        divisor  = (sample_count == 0) ? 1 : 64'(sample_count);
        quotient = (64'(pixel_sum) << FRAC_BITS) / divisor;
        if (quotient > 64'(MEAN_MAX)) begin
          quotient = 64'(MEAN_MAX);
        end
        res = '{mean_q8: quotient[MEAN_BITS-1:0], rank: RANK_VALID, present: 1'b1};
        pending_means = {pending_means, res};
        clear();
        return;
      end
      if (eor) begin
        col_phase = '0;
        row_phase = next_phase(row_phase, step_y);
      end else begin
        col_phase = next_phase(col_phase, step_x);
      end
    endfunction

    task report(string msg);
      if (errors < PRINT_LIMIT) begin
        $display("MISMATCH @%0t: %s", $time, msg);
      end
      errors++;
    endtask

    task check_mean(logic [MEAN_BITS-1:0] mean_q8, logic [RANK_BITS-1:0] rank, logic present);
      mean_result_t want;
      checked++;
      if (pending_means.size() == 0) begin
        report($sformatf("result %0d/%0d/%0d with no frame pending", mean_q8, rank, present));
        return;
      end
      want = pending_means.pop_front();
      if (mean_q8 !== want.mean_q8) begin
        report($sformatf("mean_q8 %0d, want %0d", mean_q8, want.mean_q8));
      end
      if (rank !== want.rank) begin
        report($sformatf("rank %0d, want %0d", rank, want.rank));
      end
      if (present !== want.present) begin
        report($sformatf("present %0b, want %0b", present, want.present));
      end
    endtask
  endclass

  logic                    clk = 1'b0;
  logic                    rst_n;
  logic                    cfg_we;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [STEP_BITS-1:0]    cfg_data;

  sim_in_if  px_if ();
  sim_out_if res_if ();

  frame_mean_board board = new();

  int idle_pct;
  int stall_pct;
  int hold_requests;
  int hold_served;
  int hold_left;
  int items_sent;
  int quiet;

  subsampled_image_mean_core #(
    .COUNT_BITS(COUNT_BITS),
    .STEP_BITS (STEP_BITS)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_px    (px_if),
    .out_res  (res_if),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  always @(negedge clk) begin
    if (hold_left != 0) begin
      res_if.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (hold_served != hold_requests) begin
      res_if.ready <= 1'b0;
      hold_served  <= hold_requests;
      hold_left    <= HOLD_CYCLES;
    end else begin
      res_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (res_if.valid && res_if.ready) begin
        board.check_mean(res_if.mean_q8, res_if.rank, res_if.present);
      end
      if (px_if.valid && px_if.ready) begin
        board.note_pixel(px_if.pixel, px_if.end_of_row, px_if.end_of_frame, px_if.empty_frame);
      end
    end
  end

  initial begin
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (px_if.valid && px_if.ready) || (res_if.valid && res_if.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic logic [PIXEL_BITS-1:0] pick_pixel();
    if ($urandom_range(3) == 0) begin
      return $urandom_range(1) ? 8'hFF : 8'h00;
    end
    return PIXEL_BITS'($urandom_range(255));
  endfunction

  function automatic logic [STEP_BITS-1:0] pick_stride();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2, 3: return STEP_BITS'(1);
      default: return STEP_BITS'($urandom_range(4, 2));
    endcase
  endfunction

  task automatic send_item(logic [PIXEL_BITS-1:0] px, logic eor, logic eof, logic empty);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      px_if.valid <= 1'b0;
      @(negedge clk);
    end
    px_if.valid        <= 1'b1;
    px_if.pixel        <= px;
    px_if.end_of_row   <= eor;
    px_if.end_of_frame <= eof;
    px_if.empty_frame  <= empty;
    items_sent++;
    do @(posedge clk); while (px_if.ready !== 1'b1);
  endtask

  task automatic send_frame(int w, int h, bit cut);
    int  stop_at;
    logic eor;
    logic eof;
    stop_at = cut ? $urandom_range(w * h - 1) : w * h;
    for (int n = 0; n < w * h; n++) begin
      if (n == stop_at) begin
        send_item(pick_pixel(), 1'($urandom_range(1)), 1'($urandom_range(1)), 1'b1);
        return;
      end
      eof = (n == w * h - 1);
      eor = eof ? 1'($urandom_range(1)) : ((n % w) == w - 1);
      send_item(pick_pixel(), eor, eof, 1'b0);
    end
  endtask

  task automatic settle_block();
    @(negedge clk);
    px_if.valid <= 1'b0;
    while (board.pending_means.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_stride(logic [CFG_IDX_BITS-1:0] idx, logic [STEP_BITS-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    board.set_stride(idx, value);
  endtask

  initial begin
    int idle_plan[4];
    int stall_plan[4];
    int phase_end;
    int pick;

    idle_plan          = '{0, 75, 0, 33};
    stall_plan         = '{0, 0, 75, 33};
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = CFG_STEP_X;
    cfg_data           = '0;
    px_if.valid        = 1'b0;
    px_if.pixel        = '0;
    px_if.end_of_row   = 1'b0;
    px_if.end_of_frame = 1'b0;
    px_if.empty_frame  = 1'b0;
    res_if.ready       = 1'b0;
    idle_pct           = 0;
    stall_pct          = 0;
    hold_requests      = 0;
    hold_served        = 0;
    hold_left          = 0;
    items_sent         = 0;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // single-pixel frames, marker with stray bits, partial frame dropped by a marker
    send_item(8'hFF, 1'b1, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b1, 1'b0);
    send_item(8'hFF, 1'b1, 1'b1, 1'b1);
    send_item(8'd10, 1'b0, 1'b0, 1'b0);
    send_item(8'd20, 1'b1, 1'b0, 1'b0);
    send_item(8'd30, 1'b0, 1'b0, 1'b1);
    settle_block();
    write_stride(CFG_STEP_X, '0);
    write_stride(CFG_STEP_Y, '0);
    send_item(8'd1, 1'b0, 1'b0, 1'b0);
    send_item(8'd2, 1'b0, 1'b0, 1'b0);
    send_item(8'd4, 1'b1, 1'b1, 1'b0);
    settle_block();
    write_stride(CFG_STEP_X, '1);
    write_stride(CFG_STEP_Y, '1);
    send_item(8'd200, 1'b0, 1'b0, 1'b0);
    send_item(8'd50, 1'b1, 1'b0, 1'b0);
    send_item(8'd60, 1'b0, 1'b0, 1'b0);
    send_item(8'd70, 1'b1, 1'b1, 1'b0);
    settle_block();
    write_stride(CFG_STEP_X, 10'd5);
    write_stride(CFG_STEP_Y, 10'd1);
    for (int i = 0; i < 12; i++) begin
      if (i == 4) begin
        settle_block();
        write_stride(CFG_STEP_X, 10'd2);
      end
      send_item(8'(i * 21 + 3), (i % 6) == 5, i == 11, 1'b0);
    end

    for (int ph = 0; ph < 4; ph++) begin
      settle_block();
      idle_pct  = idle_plan[ph];
      stall_pct = stall_plan[ph];
      write_stride(CFG_STEP_X, pick_stride());
      write_stride(CFG_STEP_Y, pick_stride());
      if (ph == 0) begin
        hold_requests++;
      end
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) begin
        pick = $urandom_range(99);
        if (pick < 75) begin
          if ($urandom_range(19) == 0) begin
            send_frame($urandom_range(40, 1), $urandom_range(8, 1), 1'b0);
          end else begin
            send_frame($urandom_range(12, 1), $urandom_range(6, 1), 1'b0);
          end
        end else if (pick < 88) begin
          repeat ($urandom_range(10, 1)) begin
            send_item(pick_pixel(), $urandom_range(99) < 25, $urandom_range(99) < 8,
                      $urandom_range(99) < 4);
          end
        end else begin
          send_frame($urandom_range(8, 1), $urandom_range(4, 1), 1'b1);
        end
      end
    end

    settle_block();
    $display("Covered %0d pixel transactions and %0d frame results, %0d of them empty frames,",
             items_sent, board.checked, board.empties);
    $display("over strides 0 to 1023, four pacing phases and one long result hold-off.");
    if (board.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### filelist.f
src/sim_pkg.sv
src/sim_if.sv
src/sim_ctrl.sv
src/sim_div.sv
src/sim_dp.sv
src/subsampled_image_mean_core.sv
bench/tb_subsampled_image_mean_core.sv
